FILE: hw/rtl/gcd_and_first_coprime_top_macros.svh
// assertion macros for the checker file
`ifndef GCD_AND_FIRST_COPRIME_TOP_MACROS_SVH
`define GCD_AND_FIRST_COPRIME_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GFC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/gfc_pkg.sv
// package: widths, result selects and controller/datapath interface types
`timescale 1ns / 1ps

package gfc_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

	typedef enum logic [1:0] {
		SEL_HI   = 2'd0,
		SEL_CAND = 2'd1,
		SEL_ONE  = 2'd2,
		SEL_NONE = 2'd3
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     next_cand;
		logic     div_start;
		logic     div_step;
		logic     div_end;
		logic     capture;
		res_sel_t sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic a_lt2;
		logic a_eq2;
		logic lo_zero;
		logic hi_one;
		logic cnt_last;
	} status_t;

endpackage

FILE: hw/rtl/gfc_dpath.sv
// datapath: operand registers, bit-serial remainder unit, result and output registers
`timescale 1ns / 1ps

module gfc_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gfc_pkg::cmd_t                   cmd,
	input  logic                            op_in,
	input  logic [gfc_pkg::DATA_WIDTH-1:0]  a_in,
	input  logic [gfc_pkg::DATA_WIDTH-1:0]  b_in,
	output gfc_pkg::status_t                status,
	output logic [gfc_pkg::DATA_WIDTH-1:0]  out_result,
	output logic                            out_found
);

	localparam int W = gfc_pkg::DATA_WIDTH;

	logic                      op_q;
	logic [W-1:0]              target_q;
	logic [W-1:0]              hi_q;
	logic [W-1:0]              lo_q;
	logic [W-1:0]              cand_q;
	logic [W-1:0]              rem_q;
	logic [W-1:0]              dvd_q;
	logic [gfc_pkg::CNT_W-1:0] cnt_q;
	logic [W-1:0]              res_q;
	logic                      found_q;
	logic [W-1:0]              out_res_q;
	logic                      out_found_q;

	logic [W:0]   trial;
	logic [W:0]   diff;
	logic [W-1:0] rem_next;
	logic [W-1:0] cand_inc;

	assign trial    = {rem_q, dvd_q[W-1]};
	assign diff     = trial - {1'b0, lo_q};
	assign rem_next = (trial >= {1'b0, lo_q}) ? diff[W-1:0] : trial[W-1:0];
	assign cand_inc = cand_q + W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= gfc_pkg::CNT_W'(W);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - gfc_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_in;
			target_q <= a_in;
			cand_q   <= W'(2);
			if (op_in) begin
				hi_q <= a_in;
				lo_q <= W'(2);
			end else if (a_in >= b_in) begin
				hi_q <= a_in;
				lo_q <= b_in;
			end else begin
				hi_q <= b_in;
				lo_q <= a_in;
			end
		end else if (cmd.next_cand) begin
			cand_q <= cand_inc;
			hi_q   <= target_q;
			lo_q   <= cand_inc;
		end else if (cmd.div_end) begin
			hi_q <= lo_q;
			lo_q <= rem_q;
		end

		if (cmd.div_start) begin
			rem_q <= '0;
			dvd_q <= hi_q;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[W-2:0], 1'b0};
		end

		if (cmd.capture) begin
			case (cmd.sel)
				gfc_pkg::SEL_HI: begin
					res_q   <= hi_q;
					found_q <= 1'b1;
				end
				gfc_pkg::SEL_CAND: begin
					res_q   <= cand_q;
					found_q <= 1'b1;
				end
				gfc_pkg::SEL_ONE: begin
					res_q   <= W'(1);
					found_q <= 1'b1;
				end
				default: begin
					res_q   <= '0;
					found_q <= 1'b0;
				end
			endcase
		end

		if (cmd.out_load) begin
			out_res_q   <= res_q;
			out_found_q <= found_q;
		end
	end

	assign status.op       = op_q;
	assign status.a_lt2    = (target_q < W'(2));
	assign status.a_eq2    = (target_q == W'(2));
	assign status.lo_zero  = (lo_q == '0);
	assign status.hi_one   = (hi_q == W'(1));
	assign status.cnt_last = (cnt_q == gfc_pkg::CNT_W'(1));

	assign out_result = out_res_q;
	assign out_found  = out_found_q;

endmodule

FILE: hw/rtl/gfc_ctrl.sv
// controller: sequencing state machine and output valid flag
`timescale 1ns / 1ps

module gfc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  gfc_pkg::status_t status,
	output gfc_pkg::cmd_t    cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECIDE = 6'b000010,
		ST_CHECK  = 6'b000100,
		ST_DIV    = 6'b001000,
		ST_DEND   = 6'b010000,
		ST_FIN    = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		cmd.sel = gfc_pkg::SEL_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (status.op && status.a_lt2) begin
					cmd.capture = 1'b1;
					cmd.sel     = gfc_pkg::SEL_NONE;
					state_n     = ST_FIN;
				end else if (status.op && status.a_eq2) begin
					cmd.capture = 1'b1;
					cmd.sel     = gfc_pkg::SEL_ONE;
					state_n     = ST_FIN;
				end else begin
					state_n = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!status.lo_zero) begin
					cmd.div_start = 1'b1;
					state_n       = ST_DIV;
				end else if (!status.op) begin
					cmd.capture = 1'b1;
					cmd.sel     = gfc_pkg::SEL_HI;
					state_n     = ST_FIN;
				end else if (status.hi_one) begin
					cmd.capture = 1'b1;
					cmd.sel     = gfc_pkg::SEL_CAND;
					state_n     = ST_FIN;
				end else begin
					cmd.next_cand = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.cnt_last) begin
					state_n = ST_DEND;
				end
			end
			ST_DEND: begin
				cmd.div_end = 1'b1;
				state_n     = ST_CHECK;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/gcd_and_first_coprime_top.sv
// top level: gcd and first-coprime unit with stream ports
//
//  channel | dir | tdata (low bit up)             | tuser
//  s_*     | in  | operand_a[15:0], operand_b     | opcode
//  m_*     | out | result[15:0]                   | found
//
// one item at a time; a remainder step runs through a one-bit-per-cycle
// shift-subtract unit
// an item's time grows with the remainder steps over all candidates and with
// the rejected candidates; coprime with operand_a below 3 needs no remainder step
// a new item is taken while the previous result waits in the output register
// reset clears the state machine and the output valid flag
`timescale 1ns / 1ps

module gcd_and_first_coprime_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [2*gfc_pkg::DATA_WIDTH-1:0]  s_tdata,  // operand_a, operand_b
	input  logic                              s_tuser,  // opcode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [gfc_pkg::DATA_WIDTH-1:0]    m_tdata,  // result
	output logic                              m_tuser   // found
);

	localparam int W = gfc_pkg::DATA_WIDTH;

	gfc_pkg::cmd_t    cmd;
	gfc_pkg::status_t status;

	gfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	gfc_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.op_in      (s_tuser),
		.a_in       (s_tdata[W-1:0]),
		.b_in       (s_tdata[2*W-1:W]),
		.status     (status),
		.out_result (m_tdata),
		.out_found  (m_tuser)
	);

endmodule

FILE: hw/rtl/gfc_checker.sv
// port checker for the gcd and first-coprime unit, bound to the top level
`timescale 1ns / 1ps
`include "gcd_and_first_coprime_top_macros.svh"

module gfc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [2*gfc_pkg::DATA_WIDTH-1:0]  s_tdata,
	input logic                              s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [gfc_pkg::DATA_WIDTH-1:0]    m_tdata,
	input logic                              m_tuser
);

	// stalled result holds
	`GFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// a not-found result carries zero
	`GFC_ASSERT_NOW(a_none_zero, m_tvalid && !m_tuser, m_tdata == '0, "not-found result is nonzero")

	// one item in flight: no second item right after an accept
	`GFC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input ready right after accept")

	// a result never appears in the cycle after an accept made while no result was waiting
	`GFC_ASSERT_NEXT(a_no_early_result, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result too early")

endmodule

bind gcd_and_first_coprime_top gfc_checker u_gfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: verif/tb_gcd_and_first_coprime_top.sv
// testbench for gcd_and_first_coprime_top: directed table then random items, checked by a predictor or pinned results
`timescale 1ns / 1ps

module tb_gcd_and_first_coprime_top;

	localparam int W = gfc_pkg::DATA_WIDTH;
	localparam bit OP_GCD = 1'b0;
	localparam bit OP_COPRIME = 1'b1;
	localparam int N_RANDOM = 1030;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 2000;

	typedef struct packed {
		logic [W-1:0] result;
		logic         found;
	} gfc_out_t;

	typedef struct packed {
		logic         op;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic         pinned;
		logic [W-1:0] res;
		logic         found;
	} row_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           s_tvalid = 1'b0;
	logic           s_tready;
	logic [2*W-1:0] s_tdata = '0;   // operand_a, operand_b
	logic           s_tuser = 1'b0; // opcode
	logic           m_tvalid;
	logic           m_tready = 1'b0;
	logic [W-1:0]   m_tdata;        // result
	logic           m_tuser;        // found

	// typed expectation travels alongside the item on the bus
	logic           pin_on = 1'b0;
	logic [W-1:0]   pin_res = '0;
	logic           pin_found = 1'b0;

	gfc_out_t result_q[$];
	int  errors = 0;
	int  n_gcd = 0;
	int  n_coprime = 0;
	int  n_none = 0;
	int  n_results = 0;
	bit  calm = 1'b0;
	bit  hold_req = 1'b0;
	bit  holding = 1'b0;
	bit  hold_done = 1'b0;
	row_t dir_rows [20];

	gcd_and_first_coprime_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [W-1:0] euclid(input logic [W-1:0] x, input logic [W-1:0] y);
		logic [W-1:0] hi;
		logic [W-1:0] lo;
		logic [W-1:0] r;
		hi = x;
		lo = y;
		while (lo != '0) begin
			r = hi % lo;
			hi = lo;
			lo = r;
		end
		return hi;
	endfunction

	function automatic gfc_out_t predict_result(input logic op, input logic [W-1:0] a,
			input logic [W-1:0] b);
		gfc_out_t o;
		int unsigned c;
		bit hit;
		o.result = '0;
		o.found = 1'b0;
		if (op == OP_GCD) begin
			o.result = euclid(a, b);
			o.found = 1'b1;
		end else if (a == W'(2)) begin
			o.result = W'(1);
			o.found = 1'b1;
		end else begin
			c = 2;
			hit = 1'b0;
			while (!hit && c < a) begin
				if (euclid(a, W'(c)) == W'(1)) begin
					o.result = W'(c);
					o.found = 1'b1;
					hit = 1'b1;
				end
				c++;
			end
		end
		return o;
	endfunction

	task automatic report(input string what, input logic [W-1:0] want, input logic [W-1:0] got);
		$display("mismatch %s at %0t: expected %h, got %h", what, $time, want, got);
		errors++;
	endtask

	task automatic send_item(input logic op, input logic [W-1:0] a, input logic [W-1:0] b,
			input logic pinned, input logic [W-1:0] res, input logic found);
		while (!calm && !holding && $urandom_range(0, 99) < 13) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, a};
		s_tuser <= op;
		pin_on <= pinned;
		pin_res <= res;
		pin_found <= found;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_random();
		logic op;
		logic [W-1:0] a;
		logic [W-1:0] b;
		int unsigned k;
		int unsigned base;
		int unsigned f;
		k = $urandom_range(0, 99);
		op = 1'($urandom_range(0, 1));
		a = W'($urandom);
		b = W'($urandom);
		if (op == OP_GCD) begin
			if (k < 15) begin
				a = a >> $urandom_range(0, W - 1);
				b = b >> $urandom_range(0, W - 1);
			end else if (k < 35) begin
				f = $urandom_range(1, 255);
				a = W'(f * $urandom_range(0, 255));
				b = W'(f * $urandom_range(0, 255));
			end else if (k < 42) begin
				if (k[0])
					a = '0;
				else
					b = '0;
			end
		end else begin
			if (k < 15) begin
				a = W'($urandom_range(0, 4));
			end else if (k < 40) begin
				case ($urandom_range(0, 5))
				0: base = 2;
				1: base = 6;
				2: base = 30;
				3: base = 210;
				4: base = 2310;
				default: base = 30030;
				endcase
				a = W'(base * $urandom_range(1, 65535 / base));
			end else if (k < 50) begin
				a = a >> $urandom_range(0, W - 1);
			end
		end
		send_item(op, a, b, 1'b0, '0, 1'b0);
	endtask

	always @(posedge clk) begin : scoreboard
		gfc_out_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (result_q.size() == 0) begin
					report("result with nothing pending", '0, m_tdata);
				end else begin
					e = result_q.pop_front();
					if (m_tdata !== e.result)
						report("result", e.result, m_tdata);
					if (m_tuser !== e.found)
						report("found", W'(e.found), W'(m_tuser));
				end
			end
			if (s_tvalid && s_tready) begin
				if (pin_on) begin
					e.result = pin_res;
					e.found = pin_found;
				end else begin
					e = predict_result(s_tuser, s_tdata[W-1:0], s_tdata[2*W-1:W]);
				end
				result_q.push_back(e);
				if (s_tuser == OP_GCD)
					n_gcd++;
				else
					n_coprime++;
				if (!e.found)
					n_none++;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				holding = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				holding = 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= 13);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin
		dir_rows = '{
			'{OP_GCD,     16'd0,     16'd0,     1'b1, 16'd0,     1'b1},
			'{OP_GCD,     16'd0,     16'hffff,  1'b1, 16'hffff,  1'b1},
			'{OP_GCD,     16'hffff,  16'd0,     1'b1, 16'hffff,  1'b1},
			'{OP_GCD,     16'hffff,  16'hffff,  1'b1, 16'hffff,  1'b1},
			'{OP_GCD,     16'd1,     16'd1,     1'b1, 16'd1,     1'b1},
			'{OP_GCD,     16'd7,     16'd0,     1'b1, 16'd7,     1'b1},
			'{OP_GCD,     16'd46368, 16'd28657, 1'b0, 16'd0,     1'b0},
			'{OP_GCD,     16'd28657, 16'd46368, 1'b0, 16'd0,     1'b0},
			'{OP_GCD,     16'd32768, 16'd49152, 1'b0, 16'd0,     1'b0},
			'{OP_GCD,     16'haaaa,  16'h5555,  1'b0, 16'd0,     1'b0},
			'{OP_COPRIME, 16'd0,     16'hffff,  1'b1, 16'd0,     1'b0},
			'{OP_COPRIME, 16'd1,     16'd0,     1'b1, 16'd0,     1'b0},
			'{OP_COPRIME, 16'd2,     16'h5a5a,  1'b1, 16'd1,     1'b1},
			'{OP_COPRIME, 16'd3,     16'd0,     1'b1, 16'd2,     1'b1},
			'{OP_COPRIME, 16'hffff,  16'hffff,  1'b1, 16'd2,     1'b1},
			'{OP_COPRIME, 16'd4,     16'd0,     1'b0, 16'd0,     1'b0},
			'{OP_COPRIME, 16'd30030, 16'd0,     1'b0, 16'd0,     1'b0},
			'{OP_COPRIME, 16'd60060, 16'h1234,  1'b0, 16'd0,     1'b0},
			'{OP_COPRIME, 16'd65534, 16'd0,     1'b0, 16'd0,     1'b0},
			'{OP_COPRIME, 16'd8000,  16'd0,     1'b0, 16'd0,     1'b0}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].pinned,
				dir_rows[i].res, dir_rows[i].found);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 300)
				hold_req = 1'b1;
			calm = (i >= 700 && i < 850);
			send_random();
		end
		s_tvalid <= 1'b0;
		pin_on <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		$display("covered %0d gcd items and %0d coprime searches, %0d with no coprime",
			n_gcd, n_coprime, n_none);
		$display("%0d results checked, including one long output hold-off", n_results);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
